// File: sv/tgbp_pkg.sv
// ----------------------------------------------------------------------------
// tgbp_pkg: shared constants for the text/graphics byte to pixel generator
// Palette, glyph ROM, per-mode repeat counts and slot durations.
// ----------------------------------------------------------------------------
`default_nettype none

package tgbp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRAPHICS_ENABLE = 2'd0;
    localparam logic [1:0] CFG_GRAPHICS_MODE   = 2'd1;
    localparam logic [1:0] CFG_COLOR_SET       = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 3;

    // Palette, RGBA8888
    localparam logic [31:0] PAL_GREEN       = 32'h1cd510ff;
    localparam logic [31:0] PAL_YELLOW      = 32'he2db0fff;
    localparam logic [31:0] PAL_BLUE        = 32'h0320ffff;
    localparam logic [31:0] PAL_RED         = 32'he2200aff;
    localparam logic [31:0] PAL_BUFF        = 32'hcddbe0ff;
    localparam logic [31:0] PAL_CYAN        = 32'h16d0e2ff;
    localparam logic [31:0] PAL_MAGENTA     = 32'hcb39e2ff;
    localparam logic [31:0] PAL_ORANGE      = 32'hffbb44ff;
    localparam logic [31:0] PAL_BLACK       = 32'h101010ff;
    localparam logic [31:0] PAL_DARK_GREEN  = 32'h003400ff;
    localparam logic [31:0] PAL_DARK_ORANGE = 32'h321400ff;

    localparam logic [31:0] PALETTE [8] = '{
        PAL_GREEN, PAL_YELLOW, PAL_BLUE, PAL_RED,
        PAL_BUFF, PAL_CYAN, PAL_MAGENTA, PAL_ORANGE
    };

    // Dot clock period and derived slot durations in nanoseconds
    localparam int unsigned CLOCK_PERIOD_NS = 279;
    localparam logic [11:0] SLOT_NS_8H  = 12'(CLOCK_PERIOD_NS * 8 / 2);
    localparam logic [11:0] SLOT_NS_12H = 12'(CLOCK_PERIOD_NS * 12 / 2);
    localparam logic [11:0] SLOT_NS_16H = 12'(CLOCK_PERIOD_NS * 16 / 2);
    localparam logic [11:0] SLOT_NS_24H = 12'(CLOCK_PERIOD_NS * 24 / 2);

    localparam logic [2:0] GFX_REPEAT [8] = '{
        3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1
    };

    localparam logic [11:0] GFX_SLOT_NS [8] = '{
        SLOT_NS_16H, SLOT_NS_24H, SLOT_NS_12H, SLOT_NS_16H,
        SLOT_NS_8H,  SLOT_NS_16H, SLOT_NS_8H,  SLOT_NS_8H
    };

    localparam logic [2:0] SG_REPEAT    = 3'd4;
    localparam logic [2:0] ALPHA_REPEAT = 3'd1;

    // Glyph ROM: 64 codes of 7 rows x 5 bits, row 0 leftmost in each entry
    localparam int unsigned GLYPH_ROWS  = 7;
    localparam int unsigned GLYPH_FIRST = 3;
    localparam int unsigned GLYPH_LAST  = GLYPH_FIRST + GLYPH_ROWS - 1;

    typedef logic [0:GLYPH_ROWS-1][4:0] t_glyph;

    localparam t_glyph GLYPH_ROM [64] = '{
        {5'h0e, 5'h11, 5'h10, 5'h16, 5'h15, 5'h15, 5'h0e},
        {5'h04, 5'h0a, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11},
        {5'h0f, 5'h12, 5'h12, 5'h0e, 5'h12, 5'h12, 5'h0f},
        {5'h0e, 5'h11, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0e},
        {5'h0f, 5'h12, 5'h12, 5'h12, 5'h12, 5'h12, 5'h0f},
        {5'h1f, 5'h01, 5'h01, 5'h0f, 5'h01, 5'h01, 5'h1f},
        {5'h1f, 5'h01, 5'h01, 5'h0f, 5'h01, 5'h01, 5'h01},
        {5'h1e, 5'h01, 5'h01, 5'h19, 5'h11, 5'h11, 5'h1e},
        {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
        {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
        {5'h10, 5'h10, 5'h10, 5'h10, 5'h11, 5'h11, 5'h0e},
        {5'h11, 5'h09, 5'h05, 5'h03, 5'h05, 5'h09, 5'h11},
        {5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h1f},
        {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        {5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h11, 5'h11},
        {5'h1f, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1f},
        {5'h0f, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h01},
        {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h09, 5'h16},
        {5'h0f, 5'h11, 5'h11, 5'h0f, 5'h05, 5'h09, 5'h11},
        {5'h0e, 5'h11, 5'h02, 5'h04, 5'h08, 5'h11, 5'h0e},
        {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
        {5'h11, 5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04, 5'h04},
        {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11},
        {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11},
        {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h1f, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1f},
        {5'h07, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h07},
        {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10},
        {5'h1c, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1c},
        {5'h04, 5'h0e, 5'h15, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h00, 5'h04, 5'h02, 5'h1f, 5'h02, 5'h04, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
        {5'h0a, 5'h0a, 5'h0a, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h0a, 5'h0a, 5'h1b, 5'h00, 5'h1b, 5'h0a, 5'h0a},
        {5'h04, 5'h1e, 5'h01, 5'h0e, 5'h10, 5'h0f, 5'h04},
        {5'h13, 5'h13, 5'h08, 5'h04, 5'h02, 5'h19, 5'h19},
        {5'h02, 5'h05, 5'h05, 5'h02, 5'h15, 5'h09, 5'h16},
        {5'h06, 5'h06, 5'h06, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h04, 5'h02, 5'h01, 5'h01, 5'h01, 5'h02, 5'h04},
        {5'h04, 5'h08, 5'h10, 5'h10, 5'h10, 5'h08, 5'h04},
        {5'h00, 5'h04, 5'h0e, 5'h1f, 5'h0e, 5'h04, 5'h00},
        {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h03, 5'h03, 5'h02, 5'h01},
        {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h03, 5'h03},
        {5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01},
        {5'h06, 5'h09, 5'h09, 5'h09, 5'h09, 5'h09, 5'h06},
        {5'h04, 5'h06, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
        {5'h0e, 5'h11, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1f},
        {5'h0e, 5'h11, 5'h10, 5'h0c, 5'h10, 5'h11, 5'h0e},
        {5'h08, 5'h0c, 5'h0a, 5'h1f, 5'h08, 5'h08, 5'h08},
        {5'h1f, 5'h01, 5'h0f, 5'h10, 5'h10, 5'h11, 5'h0e},
        {5'h0e, 5'h01, 5'h01, 5'h0f, 5'h11, 5'h11, 5'h0e},
        {5'h1f, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01},
        {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
        {5'h0e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h0e},
        {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00},
        {5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h04, 5'h02},
        {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08},
        {5'h00, 5'h00, 5'h1f, 5'h00, 5'h1f, 5'h00, 5'h00},
        {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02},
        {5'h06, 5'h09, 5'h08, 5'h04, 5'h04, 5'h00, 5'h04}
    };

endpackage

`default_nettype wire

// File: sv/text_graphics_byte_to_pixels.sv
// ----------------------------------------------------------------------------
// text_graphics_byte_to_pixels: display byte to pixel run generator
// Turns one display byte and its cell scan row into runs of RGBA pixels for
// alphanumeric, semigraphic and full graphics modes.
// ----------------------------------------------------------------------------
// Each accepted byte gives 2 runs (semigraphics), 4 runs (colour graphics) or
// 8 runs (alphanumeric and mono graphics), one run per clock into the output
// register while the output is not stalled. The byte is held in r_data and
// its first run is then loaded into the output register, and the next byte is
// taken in the cycle that loads the final run of the current one.
// Configuration is taken on any cycle (ready is always high) and must only
// change while the block is idle.
`default_nettype none

module text_graphics_byte_to_pixels
    import tgbp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic [3:0]             i_char_row,

    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [31:0]                 o_pixel_color,
    output logic [2:0]                  o_repeat_count,
    output logic [11:0]                 o_slot_time_ns,
    output logic                        o_last
);

    // Configuration registers
    logic       r_graphics_enable;
    logic [2:0] r_graphics_mode;
    logic       r_color_set;

    // Byte being expanded
    logic       r_busy;
    logic [7:0] r_data;
    logic [3:0] r_row;
    logic [2:0] r_idx;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_pixel_color;
    logic [2:0]  r_repeat_count;
    logic [11:0] r_slot_time_ns;
    logic        r_last;

    logic        in_take;
    logic        advance;

    logic [31:0] n_color;
    logic [2:0]  n_repeat;
    logic [11:0] n_slot_ns;
    logic        n_last;

    logic        alpha;
    logic [7:0]  glyph_mask;
    logic [4:0]  glyph_row;
    logic [2:0]  glyph_sel;
    logic [7:0]  gfx_shift;
    logic [2:0]  pal_idx;
    logic [1:0]  sg_cols;
    logic [2:0]  sg_color;
    logic        sg_bit;
    logic [31:0] alpha_bg;
    logic [31:0] alpha_fg;

    assign o_cfg_ready = 1'b1;

    assign advance    = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy && !(advance && n_last);
    assign in_take    = i_in_valid && !o_in_stall;

    // Run generator
    always_comb begin
        alpha      = !r_graphics_mode[0] && !r_data[7];
        glyph_sel  = 3'(r_row - 4'(GLYPH_FIRST));
        glyph_row  = GLYPH_ROM[r_data[5:0]][glyph_sel];
        glyph_mask = 8'h00;
        if (r_row >= 4'(GLYPH_FIRST) && r_row <= 4'(GLYPH_LAST)) begin
            glyph_mask = {1'b0, glyph_row, 2'b00};
        end
        // codes below 64 show inverted
        if (!r_data[6]) begin
            glyph_mask = ~glyph_mask;
        end
        alpha_bg = r_color_set ? PAL_DARK_ORANGE : PAL_DARK_GREEN;
        alpha_fg = r_color_set ? PALETTE[7] : PALETTE[0];

        gfx_shift = r_data << r_idx;
        pal_idx   = {r_color_set, gfx_shift[7:6]};

        if (!r_graphics_mode[0]) begin
            sg_color = r_data[6:4];
            sg_cols  = (r_row >= 4'd6) ? r_data[1:0] : r_data[3:2];
        end else begin
            sg_color = {r_color_set, r_data[7:6]};
            case (r_row[3:2])
                2'd0:    sg_cols = r_data[5:4];
                2'd1:    sg_cols = r_data[3:2];
                2'd2:    sg_cols = r_data[1:0];
                default: sg_cols = 2'b00;
            endcase
        end
        // left block takes the upper bit
        sg_bit = r_idx[0] ? sg_cols[0] : sg_cols[1];

        if (r_graphics_enable) begin
            n_repeat  = GFX_REPEAT[r_graphics_mode];
            n_slot_ns = GFX_SLOT_NS[r_graphics_mode];
            if (!r_graphics_mode[0]) begin
                // two bits per run, MSB pair first
                gfx_shift = r_data << {r_idx[1:0], 1'b0};
                pal_idx   = {r_color_set, gfx_shift[7:6]};
                n_color   = PALETTE[pal_idx];
                n_last    = (r_idx[1:0] == 2'd3);
            end else begin
                n_color = gfx_shift[7] ? (r_color_set ? PALETTE[4] : PALETTE[0])
                                       : PAL_BLACK;
                n_last  = (r_idx == 3'd7);
            end
        end else if (alpha) begin
            n_repeat  = ALPHA_REPEAT;
            n_slot_ns = SLOT_NS_8H;
            n_color   = glyph_mask[r_idx] ? alpha_bg : alpha_fg;
            n_last    = (r_idx == 3'd7);
        end else begin
            n_repeat  = SG_REPEAT;
            n_slot_ns = SLOT_NS_8H;
            n_color   = sg_bit ? PALETTE[sg_color] : PAL_BLACK;
            n_last    = r_idx[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graphics_enable <= 1'b0;
            r_graphics_mode   <= 3'd0;
            r_color_set       <= 1'b0;
            r_busy            <= 1'b0;
            r_idx             <= 3'd0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRAPHICS_ENABLE: r_graphics_enable <= i_cfg_data[0];
                    CFG_GRAPHICS_MODE:   r_graphics_mode   <= i_cfg_data;
                    CFG_COLOR_SET:       r_color_set       <= i_cfg_data[0];
                    default:             ;
                endcase
            end

            // advance the run index; wrap on the final run
            if (advance) begin
                r_idx <= n_last ? 3'd0 : r_idx + 3'd1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (in_take) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_data <= i_data_byte;
            r_row  <= i_char_row;
        end
        if (advance) begin
            r_pixel_color  <= n_color;
            r_repeat_count <= n_repeat;
            r_slot_time_ns <= n_slot_ns;
            r_last         <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_color  = r_pixel_color;
    assign o_repeat_count = r_repeat_count;
    assign o_slot_time_ns = r_slot_time_ns;
    assign o_last         = r_last;

endmodule

`default_nettype wire
